[hdl/assert_macros.svh]
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while in reset.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

[hdl/btb2_pkg.sv]
// Package for the two-bit branch target buffer: types, codes and defaults.
package btb2_pkg;

    localparam int ENTRIES_DEFAULT = 16;

    typedef enum logic [1:0]
    {
        OP_LOOKUP  = 2'd0,
        OP_INSTALL = 2'd1,
        OP_UPDATE  = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    localparam logic [1:0] CTR_STRONG_NOT   = 2'd0;
    localparam logic [1:0] CTR_STRONG_TAKEN = 2'd3;

    typedef struct packed
    {
        op_t         op;
        logic [31:0] pc;
        logic [31:0] target;
        logic        taken;
    } request_t;

    typedef struct packed
    {
        logic        hit;
        logic        predict_taken;
        logic [31:0] next_address;
        logic [1:0]  counter;
        logic        changed;
        logic        dropped;
    } result_t;

endpackage

[hdl/branch_target_buffer_2bit.sv]
// Top level of the two-bit branch target buffer.
// One operation per cycle while out_ready does not stall the result:
// the item is registered, then the whole table of ENTRIES slots is compared in
// parallel, the lowest free slot is picked and the entry is written in the same
// cycle the result register loads, so the next item sees the updated table.
// A result waiting on out_ready holds only one item in the input register;
// in_ready drops only while both registers are full and the output stalls.
module branch_target_buffer_2bit
#(
    parameter int ENTRIES = btb2_pkg::ENTRIES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [31:0] pc,
    input  logic [31:0] target,
    input  logic        taken,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic        predict_taken,
    output logic [31:0] next_address,
    output logic [1:0]  counter,
    output logic        changed,
    output logic        dropped
);

    logic               s1_valid_reg;
    btb2_pkg::request_t s1_req_reg;
    logic               out_valid_reg;
    btb2_pkg::result_t  out_res_reg;
    btb2_pkg::result_t  cam_res;
    logic               advance;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_req_reg.op     <= btb2_pkg::op_t'(op);
            s1_req_reg.pc     <= pc;
            s1_req_reg.target <= target;
            s1_req_reg.taken  <= taken;
        end
        if (advance)
        begin
            out_res_reg <= cam_res;
        end
    end

    btb2_cam
    #(
        .ENTRIES (ENTRIES)
    )
    u_cam
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .req   (s1_req_reg),
        .res   (cam_res)
    );

    assign out_valid     = out_valid_reg;
    assign hit           = out_res_reg.hit;
    assign predict_taken = out_res_reg.predict_taken;
    assign next_address  = out_res_reg.next_address;
    assign counter       = out_res_reg.counter;
    assign changed       = out_res_reg.changed;
    assign dropped       = out_res_reg.dropped;

endmodule

[hdl/btb2_cam.sv]
// Fully associative slot table: parallel match, free-slot pick and entry update.
module btb2_cam
#(
    parameter int ENTRIES = btb2_pkg::ENTRIES_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  btb2_pkg::request_t  req,
    output btb2_pkg::result_t   res
);

    localparam logic [ENTRIES-1:0] ONE = ENTRIES'(1);

    logic [ENTRIES-1:0] valid_reg;
    logic [31:0]        branch_reg  [ENTRIES];
    logic [31:0]        target_reg  [ENTRIES];
    logic [1:0]         counter_reg [ENTRIES];

    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] free_oh;
    logic               hit;
    logic               full;
    logic [31:0]        hit_target;
    logic [1:0]         hit_ctr;
    logic [1:0]         upd_ctr;
    logic               upd_changed;
    logic               install_we;
    logic               update_we;
    logic               clear_we;

    always_comb
    begin
        hit_target = '0;
        hit_ctr    = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i] = valid_reg[i] && (branch_reg[i] == req.pc);
            hit_target   = hit_target | (match_vec[i] ? target_reg[i] : 32'd0);
            hit_ctr      = hit_ctr | (match_vec[i] ? counter_reg[i] : 2'd0);
        end
    end

    assign hit      = |match_vec;
    assign full     = &valid_reg;
    assign free_vec = ~valid_reg;
    // lowest free slot, one-hot
    assign free_oh  = free_vec & (valid_reg + ONE);

    always_comb
    begin
        upd_ctr     = hit_ctr;
        upd_changed = 1'b0;
        if (req.taken && hit_ctr != btb2_pkg::CTR_STRONG_TAKEN)
        begin
            upd_ctr     = hit_ctr + 2'd1;
            upd_changed = 1'b1;
        end
        else if (!req.taken && hit_ctr != btb2_pkg::CTR_STRONG_NOT)
        begin
            upd_ctr     = hit_ctr - 2'd1;
            upd_changed = 1'b1;
        end
    end

    always_comb
    begin
        res              = '0;
        res.next_address = req.pc;
        install_we       = 1'b0;
        update_we        = 1'b0;
        clear_we         = 1'b0;
        case (req.op)
            btb2_pkg::OP_LOOKUP:
            begin
                res.hit = hit;
                if (hit)
                begin
                    res.counter       = hit_ctr;
                    res.predict_taken = hit_ctr[1];
                    res.next_address  = hit_ctr[1] ? hit_target : req.pc;
                end
            end
            btb2_pkg::OP_INSTALL:
            begin
                res.hit = hit;
                if (hit)
                begin
                    res.counter       = hit_ctr;
                    res.predict_taken = hit_ctr[1];
                    res.next_address  = hit_ctr[1] ? hit_target : req.pc;
                end
                else if (full)
                begin
                    res.dropped = 1'b1;
                end
                else
                begin
                    res.changed = 1'b1;
                    install_we  = en;
                end
            end
            btb2_pkg::OP_UPDATE:
            begin
                res.hit = hit;
                if (hit)
                begin
                    res.counter       = upd_ctr;
                    res.predict_taken = upd_ctr[1];
                    res.next_address  = upd_ctr[1] ? hit_target : req.pc;
                    res.changed       = upd_changed;
                    update_we         = en && upd_changed;
                end
            end
            btb2_pkg::OP_CLEAR:
            begin
                clear_we = en;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear_we)
        begin
            valid_reg <= '0;
        end
        else if (install_we)
        begin
            valid_reg <= valid_reg | free_oh;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (install_we && free_oh[i])
            begin
                branch_reg[i]  <= req.pc;
                target_reg[i]  <= req.target;
                counter_reg[i] <= btb2_pkg::CTR_STRONG_NOT;
            end
            else if (update_we && match_vec[i])
            begin
                counter_reg[i] <= upd_ctr;
            end
        end
    end

endmodule

[hdl/btb2_checker.sv]
// Port-level checker for the two-bit branch target buffer, with its bind.
`include "assert_macros.svh"

module btb2_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  op,
    input logic [31:0] pc,
    input logic [31:0] target,
    input logic        taken,
    input logic        out_valid,
    input logic        out_ready,
    input logic        hit,
    input logic        predict_taken,
    input logic [31:0] next_address,
    input logic [1:0]  counter,
    input logic        changed,
    input logic        dropped
);

    logic [66:0] req_bits;
    logic [37:0] res_bits;

    assign req_bits = {op, pc, target, taken};
    assign res_bits = {hit, predict_taken, next_address, counter, changed, dropped};

    // offered transfer stays put until taken
    `ASSERT_CLK(a_in_hold, clk, rst_n, in_valid && !in_ready |=> in_valid && $stable(req_bits), "input not held")

    // stalled result stays offered and unchanged
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(res_bits), "result not held")

    // refused install reads as a plain miss
    `ASSERT_CLK(a_drop_miss, clk, rst_n, out_valid && dropped |-> !hit && !changed && counter == 2'd0, "drop not a miss")

    // no entry behind a miss reports a zero counter
    `ASSERT_CLK(a_miss_ctr, clk, rst_n, out_valid && !hit && !changed |-> counter == 2'd0 && !predict_taken, "miss counter")

    // prediction is the counter's high bit
    `ASSERT_CLK(a_pred_bit, clk, rst_n, out_valid |-> predict_taken == counter[1], "prediction bit")

endmodule

bind branch_target_buffer_2bit btb2_checker u_btb2_checker (.*);

[tb/sv/tb_branch_target_buffer_2bit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the two-bit branch target buffer.
module tb_branch_target_buffer_2bit;

    localparam int SLOTS       = btb2_pkg::ENTRIES_DEFAULT;
    localparam int ITEM_TOTAL  = 1950;
    localparam int POOL_SIZE   = 24;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 8;

    typedef struct
    {
        btb2_pkg::op_t     op;
        logic [31:0]       pc;
        logic [31:0]       target;
        logic              taken;
        bit                fixed;
        btb2_pkg::result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = btb2_pkg::OP_LOOKUP;
    logic [31:0] pc = '0;
    logic [31:0] target = '0;
    logic        taken = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        hit;
    logic        predict_taken;
    logic [31:0] next_address;
    logic [1:0]  counter;
    logic        changed;
    logic        dropped;

    stim_row_t         dir_rows[$];
    stim_row_t         issued_rows[$];
    btb2_pkg::result_t pending_results[$];

    bit          btb_valid[SLOTS];
    logic [31:0] btb_branch[SLOTS];
    logic [31:0] btb_target[SLOTS];
    logic [1:0]  btb_ctr[SLOTS];

    logic [31:0] pc_pool[POOL_SIZE];

    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_hits = 0;
    int n_drops = 0;
    int n_clears = 0;
    int n_saturated = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    int calm_left = 0;
    bit burst_mode = 1'b0;

    always #5 clk = ~clk;

    branch_target_buffer_2bit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .pc            (pc),
        .target        (target),
        .taken         (taken),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .predict_taken (predict_taken),
        .next_address  (next_address),
        .counter       (counter),
        .changed       (changed),
        .dropped       (dropped)
    );

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic btb2_pkg::result_t predict_btb(btb2_pkg::op_t o, logic [31:0] p,
                                                      logic [31:0] t, logic k);
        btb2_pkg::result_t r;
        int      idx;
        int      i;
        logic [1:0] c;
        r = '0;
        r.next_address = p;
        idx = -1;
        if (o == btb2_pkg::OP_CLEAR)
        begin
            for (i = 0; i < SLOTS; i++)
                btb_valid[i] = 1'b0;
        end
        else
        begin
            for (i = 0; i < SLOTS; i++)
                if (idx < 0 && btb_valid[i] && btb_branch[i] == p)
                    idx = i;
            r.hit = (idx >= 0);
            if (o == btb2_pkg::OP_INSTALL && idx < 0)
            begin
                for (i = 0; i < SLOTS; i++)
                    if (idx < 0 && !btb_valid[i])
                        idx = i;
                if (idx < 0)
                    r.dropped = 1'b1;
                else
                begin
                    btb_valid[idx]  = 1'b1;
                    btb_branch[idx] = p;
                    btb_target[idx] = t;
                    btb_ctr[idx]    = btb2_pkg::CTR_STRONG_NOT;
                    r.changed       = 1'b1;
                end
            end
            else if (o == btb2_pkg::OP_UPDATE && idx >= 0)
            begin
                c = btb_ctr[idx];
                if (k && c != btb2_pkg::CTR_STRONG_TAKEN)
                begin
                    btb_ctr[idx] = c + 2'd1;
                    r.changed = 1'b1;
                end
                else if (!k && c != btb2_pkg::CTR_STRONG_NOT)
                begin
                    btb_ctr[idx] = c - 2'd1;
                    r.changed = 1'b1;
                end
            end
            if (idx >= 0)
            begin
                r.counter       = btb_ctr[idx];
                r.predict_taken = r.counter[1];
                if (r.predict_taken)
                    r.next_address = btb_target[idx];
            end
        end
        return r;
    endfunction

    function automatic void add_row(btb2_pkg::op_t o, logic [31:0] p, logic [31:0] t,
                                    logic k, bit fixed, btb2_pkg::result_t want);
        stim_row_t row;
        row.op     = o;
        row.pc     = p;
        row.target = t;
        row.taken  = k;
        row.fixed  = fixed;
        row.want   = want;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t row;
        int        r;
        r = $urandom_range(99);
        row.fixed  = 1'b0;
        row.want   = '0;
        row.pc     = pc_pool[$urandom_range(POOL_SIZE - 1)];
        row.target = $urandom();
        row.taken  = 1'($urandom_range(1));
        if (r < 1)
            row.op = btb2_pkg::OP_CLEAR;
        else if (r < 26)
            row.op = btb2_pkg::OP_INSTALL;
        else if (r < 66)
            row.op = btb2_pkg::OP_UPDATE;
        else if (r < 92)
            row.op = btb2_pkg::OP_LOOKUP;
        else
        begin
            // noise: any operation on an address outside the pool
            row.op = btb2_pkg::op_t'($urandom_range(3));
            row.pc = $urandom();
        end
        return row;
    endfunction

    task automatic send_item(input stim_row_t row);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        issued_rows.insert(issued_rows.size(), row);
        in_valid <= 1'b1;
        op       <= row.op;
        pc       <= row.pc;
        target   <= row.target;
        taken    <= row.taken;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Receiver back-pressure
    always @(posedge clk)
    begin
        int r;
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (calm_left > 0)
        begin
            calm_left--;
            out_ready <= 1'b1;
        end
        else
        begin
            r = $urandom_range(99);
            if (r < 5)
            begin
                calm_left = $urandom_range(50, 200);
                out_ready <= 1'b1;
            end
            else if (r < 75)
                out_ready <= 1'b1;
            else
            begin
                stall_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(9, 39);
                out_ready <= 1'b0;
            end
        end
    end

    // Prediction on input transfer, comparison on output transfer
    always @(posedge clk)
    begin
        stim_row_t         row;
        btb2_pkg::result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                n_items++;
                want = predict_btb(btb2_pkg::op_t'(op), pc, target, taken);
                if (issued_rows.size() == 0)
                    report_error("input transfer with no item issued");
                else
                begin
                    row = issued_rows.pop_front();
                    if (row.fixed)
                        want = row.want;
                end
                n_hits  += want.hit;
                n_drops += want.dropped;
                if (btb2_pkg::op_t'(op) == btb2_pkg::OP_CLEAR)
                    n_clears++;
                if (btb2_pkg::op_t'(op) == btb2_pkg::OP_UPDATE && want.hit && !want.changed)
                    n_saturated++;
                pending_results.insert(pending_results.size(), want);
            end
            if (out_valid && out_ready)
            begin
                n_results++;
                if (pending_results.size() == 0)
                    report_error("result transfer with nothing pending");
                else
                begin
                    want = pending_results.pop_front();
                    if (hit !== want.hit)
                        report_error($sformatf("result %0d: hit %b, want %b",
                                               n_results, hit, want.hit));
                    if (predict_taken !== want.predict_taken)
                        report_error($sformatf("result %0d: predict_taken %b, want %b",
                                               n_results, predict_taken, want.predict_taken));
                    if (next_address !== want.next_address)
                        report_error($sformatf("result %0d: next_address %h, want %h",
                                               n_results, next_address, want.next_address));
                    if (counter !== want.counter)
                        report_error($sformatf("result %0d: counter %0d, want %0d",
                                               n_results, counter, want.counter));
                    if (changed !== want.changed)
                        report_error($sformatf("result %0d: changed %b, want %b",
                                               n_results, changed, want.changed));
                    if (dropped !== want.dropped)
                        report_error($sformatf("result %0d: dropped %b, want %b",
                                               n_results, dropped, want.dropped));
                end
            end
        end
    end

    // Watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("branch_target_buffer_2bit regression: fail");
            $finish;
        end
        else
            idle_cycles++;
    end

    initial
    begin
        int i;
        pc_pool[0] = 32'h0000_0000;
        pc_pool[1] = 32'hFFFF_FFFF;
        for (i = 2; i < POOL_SIZE; i++)
            pc_pool[i] = $urandom();

        add_row(btb2_pkg::OP_LOOKUP,  32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1,
                {1'b0, 1'b0, 32'h0000_0000, btb2_pkg::CTR_STRONG_NOT, 1'b0, 1'b0});
        add_row(btb2_pkg::OP_INSTALL, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1,
                {1'b0, 1'b0, 32'hFFFF_FFFF, btb2_pkg::CTR_STRONG_NOT, 1'b1, 1'b0});
        add_row(btb2_pkg::OP_INSTALL, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
        add_row(btb2_pkg::OP_INSTALL, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0, 1'b0, '0);
        repeat (4)
            add_row(btb2_pkg::OP_UPDATE, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, '0);
        add_row(btb2_pkg::OP_UPDATE,  32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0);
        add_row(btb2_pkg::OP_UPDATE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
        add_row(btb2_pkg::OP_UPDATE,  32'hDEAD_BEEF, 32'h0000_0000, 1'b1, 1'b0, '0);
        // fill the remaining slots
        for (i = 0; i < SLOTS - 2; i++)
            add_row(btb2_pkg::OP_INSTALL, 32'h0000_1000 + 4 * i, ~(32'h0000_1000 + 4 * i),
                    1'b0, 1'b0, '0);
        add_row(btb2_pkg::OP_INSTALL, 32'hCAFE_F00D, 32'h5555_AAAA, 1'b1, 1'b1,
                {1'b0, 1'b0, 32'hCAFE_F00D, btb2_pkg::CTR_STRONG_NOT, 1'b0, 1'b1});
        add_row(btb2_pkg::OP_CLEAR,   32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1, 1'b1,
                {1'b0, 1'b0, 32'hA5A5_A5A5, btb2_pkg::CTR_STRONG_NOT, 1'b0, 1'b0});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i]);
        for (i = dir_rows.size(); i < ITEM_TOTAL; i++)
        begin
            if (i % 150 == 0)
                burst_mode = ($urandom_range(3) == 0);
            send_item(random_row());
        end
        in_valid <= 1'b0;

        while (issued_rows.size() != 0 || pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d operations, checked %0d results: %0d hits, %0d clears.",
                 n_items, n_results, n_hits, n_clears);
        $display("Saturated updates %0d, refused installs %0d, mismatches %0d.",
                 n_saturated, n_drops, errors);
        if (errors == 0)
            $display("branch_target_buffer_2bit regression: pass");
        else
            $display("branch_target_buffer_2bit regression: fail");
        $finish;
    end

endmodule

[branch_target_buffer_2bit.f]
+incdir+hdl
hdl/btb2_pkg.sv
hdl/btb2_cam.sv
hdl/branch_target_buffer_2bit.sv
hdl/btb2_checker.sv
tb/sv/tb_branch_target_buffer_2bit.sv
